@@ design/ipl4_pkg.sv @@
// shared types and protocol constants for the ip / layer-four header parser
`timescale 1ns / 1ps

package ipl4_pkg;

    // ip version nibble
    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    // protocol / next-header numbers
    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_ESP      = 8'd50;
    localparam logic [7:0] PROTO_AH       = 8'd51;
    localparam logic [7:0] PROTO_NONXT    = 8'd59;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
    localparam logic [7:0] PROTO_MOBILITY = 8'd135;
    localparam logic [7:0] PROTO_HIP      = 8'd139;
    localparam logic [7:0] PROTO_SHIM6    = 8'd140;

    typedef struct packed {
        logic        ok;
        logic        family;
        logic [7:0]  protocol;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_result;

    function automatic logic is_ext_hdr(input logic [7:0] p);
        return p inside {PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAGMENT, PROTO_ESP,
                         PROTO_AH, PROTO_DSTOPTS, PROTO_MOBILITY, PROTO_HIP,
                         PROTO_SHIM6, PROTO_NONXT};
    endfunction

endpackage

@@ design/ipl4_parse.sv @@
// per-byte header walk: parser state registers and next-state logic
`timescale 1ns / 1ps

module ipl4_parse #(
    parameter int OFFSET_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output ipl4_pkg::t_result o_result
);

    localparam int OB = OFFSET_BITS;
    localparam int SW = OFFSET_BITS + 1;
    localparam logic [OB-1:0] MAX_OFF = {OB{1'b1}};

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_V4    = 3'd1;
    localparam logic [2:0] PH_V6    = 3'd2;
    localparam logic [2:0] PH_EXT   = 3'd3;
    localparam logic [2:0] PH_L4    = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [OB-1:0]  r_byte_count, n_byte_count;
    logic [2:0]     r_phase, n_phase;
    logic           r_is_ipv6, n_is_ipv6;
    logic [7:0]     r_next_proto, n_next_proto;
    logic [7:0]     r_cur_ext, n_cur_ext;
    logic [OB-1:0]  r_ext_start, n_ext_start;
    logic [OB-1:0]  r_required_end, n_required_end;
    logic [OB-1:0]  r_transport_start, n_transport_start;
    logic [127:0]   r_src_addr, n_src_addr;
    logic [127:0]   r_dst_addr, n_dst_addr;
    logic [15:0]    r_src_port, n_src_port;
    logic [15:0]    r_dst_port, n_dst_port;
    logic           r_failed, n_failed;

    logic [OB-1:0]  pos;
    logic [SW-1:0]  pos_p1;
    logic [OB-1:0]  rel_ext;
    logic [OB-1:0]  rel_l4;
    logic [SW-1:0]  end_sum;
    logic [5:0]     hdr_len;
    logic           seg_done;
    logic           l4_enter;
    logic           src_wr;
    logic           dst_wr;
    logic [3:0]     addr_lane;
    logic           res_ok;

    assign pos     = r_byte_count;
    assign pos_p1  = SW'(pos) + SW'(1);
    assign rel_ext = pos - r_ext_start;
    assign rel_l4  = pos - r_transport_start;

    always_comb begin
        n_byte_count      = r_byte_count;
        n_phase           = r_phase;
        n_is_ipv6         = r_is_ipv6;
        n_next_proto      = r_next_proto;
        n_cur_ext         = r_cur_ext;
        n_ext_start       = r_ext_start;
        n_required_end    = r_required_end;
        n_transport_start = r_transport_start;
        n_src_addr        = r_src_addr;
        n_dst_addr        = r_dst_addr;
        n_src_port        = r_src_port;
        n_dst_port        = r_dst_port;
        n_failed          = r_failed;
        end_sum           = '0;
        hdr_len           = {i_byte[3:0], 2'b00};
        seg_done          = 1'b0;
        l4_enter          = 1'b0;
        src_wr            = 1'b0;
        dst_wr            = 1'b0;
        addr_lane         = '0;
        res_ok            = 1'b0;
        o_result          = '0;

        if (!r_failed) begin
            case (r_phase)
                PH_START: begin
                    if (i_byte[7:4] == ipl4_pkg::VER_IPV4) begin
                        n_phase = PH_V4;
                        if (hdr_len < 6'd20) begin
                            n_failed = 1'b1;
                        end else begin
                            n_required_end = OB'(hdr_len);
                        end
                    end else if (i_byte[7:4] == ipl4_pkg::VER_IPV6) begin
                        n_phase        = PH_V6;
                        n_is_ipv6      = 1'b1;
                        n_required_end = OB'(40);
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_V4: begin
                    if (pos == OB'(9)) begin
                        n_next_proto = i_byte;
                    end else if (pos >= OB'(12) && pos < OB'(16)) begin
                        src_wr    = 1'b1;
                        addr_lane = {2'b11, ~pos[1:0]};
                    end else if (pos >= OB'(16) && pos < OB'(20)) begin
                        dst_wr    = 1'b1;
                        addr_lane = {2'b11, ~pos[1:0]};
                    end
                    seg_done = (pos_p1 == SW'(r_required_end));
                end
                PH_V6: begin
                    if (pos == OB'(6)) begin
                        n_next_proto = i_byte;
                    end else if (pos >= OB'(8) && pos < OB'(24)) begin
                        src_wr    = 1'b1;
                        addr_lane = {pos[3], ~pos[2:0]};
                    end else if (pos >= OB'(24) && pos < OB'(40)) begin
                        dst_wr    = 1'b1;
                        addr_lane = {pos[3], ~pos[2:0]};
                    end
                    seg_done = (pos_p1 == SW'(r_required_end));
                end
                PH_EXT: begin
                    if (rel_ext == '0) begin
                        n_cur_ext    = r_next_proto;
                        n_next_proto = i_byte;
                        if (r_next_proto == ipl4_pkg::PROTO_FRAGMENT) begin
                            end_sum = SW'(r_ext_start) + SW'(8);
                            if (end_sum[OB]) begin
                                n_failed = 1'b1;
                            end else begin
                                n_required_end = end_sum[OB-1:0];
                            end
                        end
                    end else if (rel_ext == OB'(1) &&
                                 r_cur_ext != ipl4_pkg::PROTO_FRAGMENT) begin
                        if (r_cur_ext == ipl4_pkg::PROTO_AH) begin
                            end_sum = SW'(r_ext_start) +
                                      SW'({(9'(i_byte) + 9'd2), 2'b00});
                        end else begin
                            end_sum = SW'(r_ext_start) +
                                      SW'({(9'(i_byte) + 9'd1), 3'b000});
                        end
                        if (end_sum[OB]) begin
                            n_failed = 1'b1;
                        end else begin
                            n_required_end = end_sum[OB-1:0];
                        end
                    end
                    seg_done = !n_failed && (pos_p1 == SW'(n_required_end)) &&
                               (rel_ext != '0 || n_cur_ext == ipl4_pkg::PROTO_FRAGMENT);
                end
                PH_L4: begin
                    if (rel_l4 == '0) begin
                        n_src_port = {i_byte, 8'h00};
                    end else if (rel_l4 == OB'(1)) begin
                        n_src_port = {r_src_port[15:8], i_byte};
                    end else if (rel_l4 == OB'(2)) begin
                        n_dst_port = {i_byte, 8'h00};
                    end else if (rel_l4 == OB'(3)) begin
                        n_dst_port = {r_dst_port[15:8], i_byte};
                    end else if (rel_l4 == OB'(12) && r_next_proto == ipl4_pkg::PROTO_TCP) begin
                        if (i_byte[7:4] < 4'd5) begin
                            n_failed = 1'b1;
                        end else begin
                            end_sum = SW'(r_transport_start) + SW'({i_byte[7:4], 2'b00});
                            if (end_sum[OB]) begin
                                n_failed = 1'b1;
                            end else begin
                                n_required_end = end_sum[OB-1:0];
                            end
                        end
                    end
                    if (!n_failed && pos_p1 == SW'(n_required_end)) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // end of an ip or extension header
        if (seg_done) begin
            if (r_phase == PH_V4) begin
                l4_enter = 1'b1;
            end else if (n_next_proto == ipl4_pkg::PROTO_NONXT ||
                         n_next_proto == ipl4_pkg::PROTO_ESP) begin
                n_failed = 1'b1;
            end else if (ipl4_pkg::is_ext_hdr(n_next_proto)) begin
                n_phase     = PH_EXT;
                n_ext_start = n_required_end;
            end else begin
                l4_enter = 1'b1;
            end
        end

        if (l4_enter) begin
            n_transport_start = n_required_end;
            if (n_next_proto == ipl4_pkg::PROTO_TCP ||
                n_next_proto == ipl4_pkg::PROTO_UDP) begin
                n_phase = PH_L4;
                if (n_next_proto == ipl4_pkg::PROTO_TCP) begin
                    end_sum = SW'(n_required_end) + SW'(20);
                end else begin
                    end_sum = SW'(n_required_end) + SW'(8);
                end
                if (end_sum[OB]) begin
                    n_failed = 1'b1;
                end else begin
                    n_required_end = end_sum[OB-1:0];
                end
            end else begin
                n_phase = PH_DONE;
            end
        end

        for (int i = 0; i < 16; i++) begin
            if (src_wr && addr_lane == 4'(i)) begin
                n_src_addr[i*8 +: 8] = i_byte;
            end
            if (dst_wr && addr_lane == 4'(i)) begin
                n_dst_addr[i*8 +: 8] = i_byte;
            end
        end

        // result for the last beat
        res_ok = !n_failed && (n_phase == PH_DONE);
        if (res_ok) begin
            o_result.ok          = 1'b1;
            o_result.family      = n_is_ipv6;
            o_result.protocol    = n_next_proto;
            o_result.src_addr_hi = n_src_addr[127:64];
            o_result.src_addr_lo = n_src_addr[63:0];
            o_result.dst_addr_hi = n_dst_addr[127:64];
            o_result.dst_addr_lo = n_dst_addr[63:0];
            if (n_next_proto == ipl4_pkg::PROTO_TCP ||
                n_next_proto == ipl4_pkg::PROTO_UDP) begin
                o_result.src_port = n_src_port;
                o_result.dst_port = n_dst_port;
            end
        end

        if (i_last) begin
            n_byte_count      = '0;
            n_phase           = PH_START;
            n_is_ipv6         = 1'b0;
            n_next_proto      = '0;
            n_cur_ext         = '0;
            n_ext_start       = '0;
            n_required_end    = '0;
            n_transport_start = '0;
            n_src_addr        = '0;
            n_dst_addr        = '0;
            n_src_port        = '0;
            n_dst_port        = '0;
            n_failed          = 1'b0;
        end else if (r_byte_count != MAX_OFF) begin
            n_byte_count = r_byte_count + OB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count      <= '0;
            r_phase           <= PH_START;
            r_is_ipv6         <= 1'b0;
            r_next_proto      <= '0;
            r_cur_ext         <= '0;
            r_ext_start       <= '0;
            r_required_end    <= '0;
            r_transport_start <= '0;
            r_src_addr        <= '0;
            r_dst_addr        <= '0;
            r_src_port        <= '0;
            r_dst_port        <= '0;
            r_failed          <= 1'b0;
        end else if (i_step) begin
            r_byte_count      <= n_byte_count;
            r_phase           <= n_phase;
            r_is_ipv6         <= n_is_ipv6;
            r_next_proto      <= n_next_proto;
            r_cur_ext         <= n_cur_ext;
            r_ext_start       <= n_ext_start;
            r_required_end    <= n_required_end;
            r_transport_start <= n_transport_start;
            r_src_addr        <= n_src_addr;
            r_dst_addr        <= n_dst_addr;
            r_src_port        <= n_src_port;
            r_dst_port        <= n_dst_port;
            r_failed          <= n_failed;
        end
    end

endmodule

@@ design/ip_l4_header_parser.sv @@
// top level of the ip / layer-four header parser with input and result registers
`timescale 1ns / 1ps

// usage:
//   slave channel s_* carries the packet one byte per beat, starting at the
//   ip header; s_tlast marks the final byte of the packet.
//   master channel m_* carries one result beat per packet: m_tuser holds the
//   ok and family flags, m_tdata the protocol, both addresses and the ports.
// output: the last byte of a packet is taken into the input register, and its
//   result is written to the result register, and so onto m_*, once that is free.
// throughput: one byte per clock, sustained across packet boundaries while the
//   result register is free (see stall); the byte step is one pass of compare
//   and add logic between the input register and the parser state.
// stall: while a result waits on m_tready, non-last bytes of the next packet
//   keep flowing; only a last byte is held in the input register, and then
//   s_tready drops until the waiting result is taken.
// reset: i_rst_n low on a clock edge empties both registers and returns the
//   parser to the start of a packet.

module ip_l4_header_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // packet_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // protocol[7:0], src_addr_hi[71:8], src_addr_lo[135:72],
    // dst_addr_hi[199:136], dst_addr_lo[263:200], src_port[279:264],
    // dst_port[295:280]
    output logic [295:0] m_tdata,
    output logic [1:0]   m_tuser    // ok[0], family[1]
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    ipl4_pkg::t_result r_out;
    ipl4_pkg::t_result step_result;
    logic              out_free;
    logic              step;

    assign out_free = !r_out_valid || m_tready;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign s_tready = !r_in_valid || step;

    ipl4_parse #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_result(step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = {r_out.family, r_out.ok};
    assign m_tdata  = {r_out.dst_port, r_out.src_port,
                       r_out.dst_addr_lo, r_out.dst_addr_hi,
                       r_out.src_addr_lo, r_out.src_addr_hi,
                       r_out.protocol};

    // a held last byte moves into the result register once it is free
    a_last_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && out_free |=> m_tvalid)
        else $error("last byte did not produce a result beat");

    // failed parse carries nothing but zeros
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("failed result with nonzero fields");

    // ipv4 leaves the low address words empty
    a_v4_lo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] && !m_tuser[1] |->
            m_tdata[135:72] == '0 && m_tdata[263:200] == '0)
        else $error("ipv4 result with low address bits set");

    // ports only for tcp and udp
    a_ports_l4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[7:0] != ipl4_pkg::PROTO_TCP &&
            m_tdata[7:0] != ipl4_pkg::PROTO_UDP |-> m_tdata[295:264] == '0)
        else $error("ports reported for a protocol without ports");

endmodule
